// File: hw/rtl/arx_pkg.sv
package arx_pkg;

    localparam int ROUNDS_DEFAULT = 48;
    localparam int WARMUP_PER_ROUND = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_PART0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_PART1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_PART2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_PART3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IV_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IV_LOW = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE = 3'd6;

    typedef struct packed {
        logic [31:0] word_in0;
        logic [31:0] word_in1;
        logic [31:0] word_in2;
        logic [31:0] word_in3;
        logic        restart;
    } in_word_t;

    typedef struct packed {
        logic [31:0] word_out0;
        logic [31:0] word_out1;
        logic [31:0] word_out2;
        logic [31:0] word_out3;
    } out_word_t;

    typedef logic [7:0][31:0] gen_state_t;

    function automatic logic [31:0] rotr32(input logic [31:0] v, input int n);
        rotr32 = (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
        rotl32 = (v << n) | (v >> (32 - n));
    endfunction

    // one key generator step, words updated in order
    function automatic gen_state_t gen_step(input gen_state_t g_in);
        gen_state_t g;
        g = g_in;
        g[0] = (rotr32(g[0], 8) + g[4]) ^ g[6];
        g[1] = (rotr32(g[1], 7) + g[2]) ^ g[0];
        g[2] = rotr32(g[2], 2) ^ g[1];
        g[3] = (rotl32(g[3], 3) ^ g[5]) + g[7];
        g[4] = (rotr32(g[5], 8) + g[3]) ^ g[2];
        g[5] = (rotr32(g[5], 7) + g[0]) ^ g[6];
        g[6] = rotr32(g[6], 2) ^ g[2];
        g[7] = (rotl32(g[7], 3) ^ g[4]) + g[5];
        gen_step = g;
    endfunction

    function automatic logic [31:0] gen_fold(input gen_state_t g);
        gen_fold = g[0] ^ g[1] ^ g[2] ^ g[3] ^ g[4] ^ g[5] ^ g[6] ^ g[7];
    endfunction

endpackage

// File: hw/rtl/arx_block_cipher_cbc.sv
// ARX block cipher, CBC mode, one 128-bit word per handshake.
// Input channel s_valid/s_ready carries four big-endian 32-bit lanes and a
// restart flag; result channel m_valid/m_ready carries four lanes.
// Configuration: cfg_we/cfg_index/cfg_data. The user must write it only
// while idle; the block itself does not enforce this. A plain word goes
// from accept to m_valid through a load cycle and then the rounds, one
// cycle per round through the shared round unit. A word with restart set
// first runs key expansion: 6*ROUNDS warm-up generator steps, then
// 6*ROUNDS steps filling the key memories, one step per cycle. Decrypt
// walks the key memories from the last round down, one synchronous read
// per cycle. The block holds one word at a time; s_ready is low from
// accept until the result has been taken. With an always-ready receiver
// each word passes the load cycle, the rounds and the result state, and
// the block returns to idle before it accepts the next word.
// A stalled receiver holds m_valid and the result.
// Reset (aresetn low, synchronous) clears the handshake state, the
// configuration registers and the chain value; the key memories stay
// undefined until the first restart.
module arx_block_cipher_cbc
    import arx_pkg::*;
#(
    parameter int ROUNDS = ROUNDS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_word_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_word_t             m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int RW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
    localparam int GEN_STEPS = WARMUP_PER_ROUND * ROUNDS;
    localparam int GW = $clog2(GEN_STEPS + 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_WARM   = 5'b00010,
        ST_FILL   = 5'b00100,
        ST_ROUND  = 5'b01000,
        ST_OUT    = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [63:0] key0_reg, key1_reg, key2_reg, key3_reg, ivh_reg, ivl_reg;
    logic        dec_reg;

    logic [31:0] mem_a [ROUNDS];
    logic [31:0] mem_b [ROUNDS];
    logic [127:0] mem_add [ROUNDS];

    gen_state_t  gen_reg;
    logic [GW-1:0] gcnt_reg;
    logic [2:0]  slot_reg;
    logic [RW-1:0] fround_reg;
    logic [31:0] hold_a_reg;
    logic [95:0] hold_add_reg;

    logic [RW-1:0] round_reg;
    logic [RW-1:0] rd_addr;
    logic        first_reg;
    logic [31:0] ka_q, kb_q;
    logic [127:0] kadd_q;

    logic [127:0] chain_reg;
    logic [127:0] blk_reg;
    logic [127:0] held_reg;
    out_word_t   out_reg;

    gen_state_t  gen_nx;
    logic [31:0] gen_out;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key0_reg <= '0; key1_reg <= '0; key2_reg <= '0; key3_reg <= '0;
            ivh_reg <= '0; ivl_reg <= '0; dec_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_KEY_PART0:    key0_reg <= cfg_data;
                REG_KEY_PART1:    key1_reg <= cfg_data;
                REG_KEY_PART2:    key2_reg <= cfg_data;
                REG_KEY_PART3:    key3_reg <= cfg_data;
                REG_IV_HIGH:      ivh_reg <= cfg_data;
                REG_IV_LOW:       ivl_reg <= cfg_data;
                REG_DECRYPT_MODE: dec_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign gen_nx = gen_step(gen_reg);
    assign gen_out = gen_fold(gen_nx);

    // key memory read address: counts up to encrypt, down to decrypt;
    // the load cycle re-reads the first round's keys
    always_comb begin
        rd_addr = round_reg;
        if (state_reg == ST_IDLE || (state_reg == ST_FILL && gcnt_reg == GW'(GEN_STEPS - 1)))
            rd_addr = dec_reg ? RW'(ROUNDS - 1) : '0;
        else if (state_reg == ST_ROUND && !first_reg)
            rd_addr = dec_reg ? RW'(round_reg - RW'(1)) : RW'(round_reg + RW'(1));
    end

    // key memories, fill writes and registered reads
    always_ff @(posedge aclk) begin
        if (state_reg == ST_FILL) begin
            if (gcnt_reg < GW'(2 * ROUNDS)) begin
                if (slot_reg[0]) mem_b[fround_reg] <= gen_out;
                else hold_a_reg <= gen_out;
                if (slot_reg[0]) mem_a[fround_reg] <= hold_a_reg;
            end else begin
                if (slot_reg[1:0] == 2'd3)
                    mem_add[fround_reg] <= {hold_add_reg, gen_out};
                else
                    hold_add_reg <= {hold_add_reg[63:0], gen_out};
            end
        end
        ka_q <= mem_a[rd_addr];
        kb_q <= mem_b[rd_addr];
        kadd_q <= mem_add[rd_addr];
    end

    // one forward or inverse round on the working word
    logic [31:0] a0, b0, c0, d0, ra, rb, rc, rd;
    logic [31:0] ad0, ad1, ad2, ad3;
    logic [31:0] t_a, t_b, t_c, t_d;
    always_comb begin
        {a0, b0, c0, d0} = blk_reg;
        {ad0, ad1, ad2, ad3} = kadd_q;
        if (!dec_reg) begin
            t_a = (rotr32(a0, 8) + d0) ^ ka_q;
            t_b = (rotr32(b0, 7) + c0) ^ kb_q;
            t_c = rotl32(c0, 2) ^ t_b;
            t_d = rotl32(d0, 3) ^ t_a;
            t_a = t_a + t_b;
            t_b = t_b + t_a;
            ra = t_a + ad0; rb = t_b + ad1; rc = t_c + ad2; rd = t_d + ad3;
        end else begin
            t_d = d0 - ad3; t_c = c0 - ad2; t_b = b0 - ad1; t_a = a0 - ad0;
            t_b = t_b - t_a;
            t_a = t_a - t_b;
            rd = rotr32(t_d ^ t_a, 3);
            rc = rotr32(t_c ^ t_b, 2);
            rb = rotl32((t_b ^ kb_q) - rc, 7);
            ra = rotl32((t_a ^ ka_q) - rd, 8);
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_valid) state_next = s_data.restart ? ST_WARM : ST_ROUND;
            ST_WARM:  if (gcnt_reg == GW'(GEN_STEPS - 1)) state_next = ST_FILL;
            ST_FILL:  if (gcnt_reg == GW'(GEN_STEPS - 1)) state_next = ST_ROUND;
            ST_ROUND: if (!first_reg && round_reg == (dec_reg ? '0 : RW'(ROUNDS - 1)))
                          state_next = ST_OUT;
            ST_OUT:   if (m_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // sequencer and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            chain_reg <= '0;
            gcnt_reg <= '0;
            first_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE: if (s_valid) begin
                    gcnt_reg <= '0;
                    first_reg <= 1'b1;
                    round_reg <= dec_reg ? RW'(ROUNDS - 1) : '0;
                    held_reg <= s_data[128:1];
                    gen_reg <= {key3_reg[31:0], key3_reg[63:32], key2_reg[31:0],
                                key2_reg[63:32], key1_reg[31:0], key1_reg[63:32],
                                key0_reg[31:0], key0_reg[63:32]};
                    if (s_data.restart) chain_reg <= {ivh_reg, ivl_reg};
                    else blk_reg <= dec_reg ? s_data[128:1] : (s_data[128:1] ^ chain_reg);
                end
                ST_WARM: begin
                    gen_reg <= gen_nx;
                    gcnt_reg <= (gcnt_reg == GW'(GEN_STEPS - 1)) ? '0 : gcnt_reg + GW'(1);
                    slot_reg <= '0;
                    fround_reg <= '0;
                end
                ST_FILL: begin
                    gen_reg <= gen_nx;
                    gcnt_reg <= gcnt_reg + GW'(1);
                    if (gcnt_reg == GW'(2 * ROUNDS - 1)) begin
                        slot_reg <= '0;
                        fround_reg <= '0;
                    end else if (gcnt_reg < GW'(2 * ROUNDS)) begin
                        slot_reg <= {2'b00, ~slot_reg[0]};
                        if (slot_reg[0]) fround_reg <= fround_reg + RW'(1);
                    end else begin
                        slot_reg <= {1'b0, slot_reg[1:0] + 2'd1};
                        if (slot_reg[1:0] == 2'd3) fround_reg <= fround_reg + RW'(1);
                    end
                    blk_reg <= dec_reg ? held_reg : (held_reg ^ chain_reg);
                end
                ST_ROUND: begin
                    if (first_reg) first_reg <= 1'b0;
                    else begin
                        blk_reg <= {ra, rb, rc, rd};
                        round_reg <= dec_reg ? RW'(round_reg - RW'(1)) : RW'(round_reg + RW'(1));
                        if (state_next == ST_OUT) begin
                            out_reg <= dec_reg ? ({ra, rb, rc, rd} ^ chain_reg) : {ra, rb, rc, rd};
                            chain_reg <= dec_reg ? held_reg : {ra, rb, rc, rd};
                        end
                    end
                end
                ST_OUT: ;
                default: ;
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign m_data = out_reg;

    a_one_hot: assert property (@(posedge aclk) disable iff (!aresetn) $onehot(state_reg))
        else $error("state not one-hot");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn) !(s_ready && m_valid))
        else $error("ready while result pending");
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |=> s_ready)
        else $error("not idle after result taken");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed while stalled");

endmodule
